// ===== rtl/core/ipvfl_pkg.sv =====
// shared types, constants and sizes for the ipv4 forwarding lookup block
// no dependencies; used by ipvfl_cell and ipv4_forward_lookup
package ipvfl_pkg;

    localparam int ENTRIES    = 128;
    localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W      = 7;
    localparam int CMP_W      = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
    localparam int FIFO_DEPTH = 2 ** $clog2(ENTRIES + 4);
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [16:0] CSUM_ONES        = 17'h0ffff;
    localparam logic [7:0]  DEFAULT_PORT_RST = 8'd4;
    localparam logic [7:0]  TTL_STEP_RST     = 8'd1;

    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_DEFAULT_PORT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_TTL_STEP     = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] ether_type;
        logic [7:0]  ttl_in;
        logic [31:0] dest_addr;
        logic [15:0] checksum_in;
        logic [31:0] meta_in;
        logic [6:0]  entry_index;
        logic [23:0] entry_prefix;
        logic [7:0]  entry_port;
    } in_word_t;

    typedef struct packed {
        logic [31:0] meta_out;
        logic [7:0]  ttl_out;
        logic [15:0] checksum_out;
        logic [7:0]  out_port;
        logic        forwarded;
        logic        matched;
    } out_word_t;

    // token walking the cell chain
    typedef struct packed {
        logic             valid;
        logic             is_write;
        logic             fwd;
        logic [23:0]      prefix;
        logic [IDX_W-1:0] index;
        logic [7:0]       port;
        logic             hit;
    } tok_t;

    // header fields parked in the side fifo while the token walks
    typedef struct packed {
        logic [31:0] meta;
        logic [7:0]  ttl;
        logic [15:0] checksum;
    } side_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

// ===== rtl/core/ipvfl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module ipvfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ipvfl_cell.sv =====
// one route slot of the lookup chain: stores a prefix and port, applies
// table writes addressed to it and tags passing lookups; uses ipvfl_pkg
module ipvfl_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ipvfl_pkg::SLOT_W-1:0] cell_id,
    input  ipvfl_pkg::tok_t              tok_in,
    output ipvfl_pkg::tok_t              tok_out
);

    logic                 valid_reg;
    logic [23:0]          prefix_reg;
    logic [7:0]           port_reg;
    ipvfl_pkg::tok_t      tok_reg;
    ipvfl_pkg::tok_t      tok_next;
    logic                 wr_here;
    logic                 hit_here;

    always_comb
    begin
        wr_here  = tok_in.valid && tok_in.is_write &&
                   (ipvfl_pkg::CMP_W'(tok_in.index) == ipvfl_pkg::CMP_W'(cell_id));
        hit_here = tok_in.valid && !tok_in.is_write && !tok_in.hit &&
                   valid_reg && (prefix_reg == tok_in.prefix);
        tok_next = tok_in;
        if (hit_here)
        begin
            tok_next.hit  = 1'b1;
            tok_next.port = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    // slot contents, qualified by valid_reg
    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            prefix_reg <= tok_in.prefix;
            port_reg   <= tok_in.port;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/ipv4_forward_lookup.sv =====
// top level of the ipv4 forwarding step: cell chain route table, side fifo
// and result stage; uses ipvfl_pkg, ipvfl_cell and ipvfl_ram
//
// usage
//   input: a word on in_word is taken at a rising edge with start high and
//   busy low. kind 1 writes a route slot and gives no result; kind 0 is a
//   packet header and always gives exactly one result word.
//   output: done is high for one cycle with the result word on out_word;
//   the receiver takes it at that edge and cannot hold it off.
//   config: cfg_we writes cfg_wdata into register cfg_addr (0 default port,
//   1 ttl step); user must write only with no item in flight; not enforced.
// timing
//   one word accepted every cycle; a packet's result is taken through the
//   chain, which moves every word one route slot further each cycle, then
//   through the tail and fifo read registers and the result register.
// reset
//   all slots invalid, default port 4, ttl step 1; busy is high until the
//   first clock edge after reset is released, then stays low
module ipv4_forward_lookup (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ipvfl_pkg::in_word_t          in_word,
    output logic                         done,
    output ipvfl_pkg::out_word_t         out_word,
    input  logic                         cfg_we,
    input  logic [ipvfl_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [7:0]                   cfg_wdata
);

    // ---------------------------------------------------------------
    // control and configuration registers
    // ---------------------------------------------------------------
    logic                          busy_reg;
    logic [7:0]                    default_port_reg;
    logic [7:0]                    ttl_step_reg;
    logic [ipvfl_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [ipvfl_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic                          fin_valid_reg;
    ipvfl_pkg::tok_t               fin_reg;
    logic                          done_reg;
    ipvfl_pkg::out_word_t          out_reg;
    ipvfl_pkg::out_word_t          out_next;

    logic                          accept;
    logic                          push;
    logic                          pop;
    ipvfl_pkg::tok_t               tok_head;
    ipvfl_pkg::tok_t               tok [ipvfl_pkg::ENTRIES + 1];
    ipvfl_pkg::side_t              side_wr;
    ipvfl_pkg::side_t              side_rd;
    logic [ipvfl_pkg::SIDE_W-1:0]  side_rdata;
    logic [7:0]                    port_sel;
    logic [16:0]                   csum_sum;

    assign accept = start && !busy_reg;
    assign push   = accept && !in_word.kind;

    // ---------------------------------------------------------------
    // head of the chain: writes carry the new slot, packets their key
    // ---------------------------------------------------------------
    always_comb
    begin
        tok_head.valid    = accept;
        tok_head.is_write = in_word.kind;
        tok_head.fwd      = (in_word.ether_type == ipvfl_pkg::ETHERTYPE_IPV4) &&
                            (in_word.ttl_in != 8'd0);
        tok_head.prefix   = in_word.kind ? in_word.entry_prefix : in_word.dest_addr[31:8];
        tok_head.index    = in_word.entry_index;
        tok_head.port     = in_word.kind ? in_word.entry_port : 8'd0;
        tok_head.hit      = 1'b0;
    end

    assign tok[0] = tok_head;

    // slot k is seen in order, so the first match met is the lowest slot
    for (genvar k = 0; k < ipvfl_pkg::ENTRIES; k++)
    begin : g_cell
        ipvfl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (ipvfl_pkg::SLOT_W'(k)),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    // ---------------------------------------------------------------
    // side fifo: header fields wait here while the key walks the chain;
    // packets leave the chain in the order they entered
    // ---------------------------------------------------------------
    assign side_wr.meta     = in_word.meta_in;
    assign side_wr.ttl      = in_word.ttl_in;
    assign side_wr.checksum = in_word.checksum_in;

    assign pop = tok[ipvfl_pkg::ENTRIES].valid && !tok[ipvfl_pkg::ENTRIES].is_write;

    ipvfl_ram #(
        .WIDTH (ipvfl_pkg::SIDE_W),
        .DEPTH (ipvfl_pkg::FIFO_DEPTH)
    ) u_side_ram (
        .clk   (clk),
        .we    (push),
        .waddr (wr_ptr_reg),
        .wdata (side_wr),
        .re    (pop),
        .raddr (rd_ptr_reg),
        .rdata (side_rdata)
    );

    assign side_rd = side_rdata;

    // ---------------------------------------------------------------
    // result stage
    // ---------------------------------------------------------------
    always_comb
    begin
        port_sel = fin_reg.hit ? fin_reg.port : default_port_reg;
        // incremental update for ttl in the high byte, end-around carry
        csum_sum = {1'b0, side_rd.checksum} + {1'b0, ttl_step_reg, 8'h00};
        if (csum_sum >= ipvfl_pkg::CSUM_ONES)
        begin
            csum_sum = csum_sum - ipvfl_pkg::CSUM_ONES;
        end

        out_next.meta_out     = side_rd.meta;
        out_next.ttl_out      = side_rd.ttl;
        out_next.checksum_out = side_rd.checksum;
        out_next.out_port     = 8'd0;
        out_next.forwarded    = 1'b0;
        out_next.matched      = 1'b0;
        if (fin_reg.fwd)
        begin
            out_next.meta_out     = side_rd.meta | {8'h00, port_sel, 16'h0000};
            out_next.ttl_out      = side_rd.ttl - ttl_step_reg;
            out_next.checksum_out = csum_sum[15:0];
            out_next.out_port     = port_sel;
            out_next.forwarded    = 1'b1;
            out_next.matched      = fin_reg.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b1;
            default_port_reg <= ipvfl_pkg::DEFAULT_PORT_RST;
            ttl_step_reg     <= ipvfl_pkg::TTL_STEP_RST;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fin_valid_reg    <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            busy_reg      <= 1'b0;
            fin_valid_reg <= pop;
            done_reg      <= fin_valid_reg;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    ipvfl_pkg::CFG_DEFAULT_PORT: default_port_reg <= cfg_wdata;
                    ipvfl_pkg::CFG_TTL_STEP:     ttl_step_reg     <= cfg_wdata;
                    default:                     ;
                endcase
            end
        end
    end

    // payload of the tail token and of the result word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            fin_reg <= tok[ipvfl_pkg::ENTRIES];
        end
        if (fin_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign out_word = out_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // a packet leaving the chain always finds its header in the fifo
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("side fifo read while empty");

    // packets in flight never exceed the chain length plus the head slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (ipvfl_pkg::FIFO_AW'(wr_ptr_reg - rd_ptr_reg) <=
         ipvfl_pkg::FIFO_AW'(ipvfl_pkg::ENTRIES + 1)))
        else $error("side fifo holds too many headers");

    // a match is only reported for a forwarded packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_reg.matched) |-> out_reg.forwarded)
        else $error("match flagged on a packet that was not forwarded");

    // a forwarded miss carries the default port
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && out_reg.forwarded && !out_reg.matched) |->
        (out_reg.out_port == default_port_reg))
        else $error("forwarded miss without the default port");

    // a word that was not forwarded passes with no port
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !out_reg.forwarded) |-> (out_reg.out_port == 8'd0))
        else $error("port set on a packet that was not forwarded");

endmodule
